// ----- hw/rtl/radix_string_to_integer_defines.svh -----
`ifndef RADIX_STRING_TO_INTEGER_DEFINES_SVH
`define RADIX_STRING_TO_INTEGER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define RSTI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsti assertion failed");

// Next-cycle implication, checked outside of reset.
`define RSTI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsti assertion failed");

`endif

// ----- hw/rtl/rsti_pkg.sv -----
`default_nettype none

package rsti_pkg;

	localparam int MAX_SYMBOLS = 32;
	localparam int IDX_W       = $clog2(MAX_SYMBOLS);
	localparam int CNT_W       = 6;
	localparam int CHAR_W      = 8;
	localparam int VALUE_W     = 32;
	localparam int NUM_WORDS   = 4;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_0    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_8    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_16   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_24   = 3'd4;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		PH_SPACE,
		PH_SIGN,
		PH_DIGIT,
		PH_STOP
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              is_last;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      alphabet_invalid;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]                   len;
		logic                               bad;
		logic [MAX_SYMBOLS-1:0][CHAR_W-1:0] symbols;
	} alpha_t;

endpackage

`default_nettype wire

// ----- hw/rtl/radix_string_to_integer.sv -----
// A result is registered in the output stage when the last character leaves the input stage.
// Throughput: one character per cycle, set by the combinational multiply-add that folds each digit
// into the accumulator, but a last character stalls while an earlier result is still held.
// Reset (arst_n low, asynchronous) clears all configuration registers to zero,
// returns the parser to whitespace skipping and drops any pending result.
`default_nettype none

`include "radix_string_to_integer_defines.svh"

module radix_string_to_integer
	import rsti_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output result_t                    result
);

	alpha_t alpha;

	rsti_alpha u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.alpha     (alpha)
	);

	rsti_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.alpha        (alpha)
	);

	`RSTI_ASSERT_NOW(a_bad_gives_minus_one, clk, arst_n, result_valid && result.alphabet_invalid, result.value == -32'sd1)
	`RSTI_ASSERT_NOW(a_stall_only_on_held_result, clk, arst_n, !item_ready, result_valid && !result_ready)
	`RSTI_ASSERT_NEXT(a_result_waits, clk, arst_n, result_valid && !result_ready, result_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/rsti_alpha.sv -----
`default_nettype none

module rsti_alpha
	import rsti_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output alpha_t                     alpha
);

	logic [CNT_W-1:0]                          count_q;
	logic [NUM_WORDS-1:0][CFG_DATA_W-1:0]      words_q;
	logic [NUM_WORDS*8-1:0][CHAR_W-1:0]        sym_all;
	logic [MAX_SYMBOLS-1:0][CHAR_W-1:0]        sym;
	logic [CNT_W-1:0]                          len_q;
	logic                                      bad_q;
	logic [CNT_W-1:0]                          n_c;
	logic [CNT_W-1:0]                          len_c;
	logic                                      bad_c;

	assign cfg_ready = 1'b1;
	assign sym_all   = words_q;
	assign sym       = sym_all[MAX_SYMBOLS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			words_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SYMBOL_COUNT: count_q    <= cfg_data[CNT_W-1:0];
				REG_SYMBOLS_0:    words_q[0] <= cfg_data;
				REG_SYMBOLS_8:    words_q[1] <= cfg_data;
				REG_SYMBOLS_16:   words_q[2] <= cfg_data;
				REG_SYMBOLS_24:   words_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The alphabet ends at the first zero byte within the configured count.
	always_comb begin
		n_c = (count_q > CNT_W'(MAX_SYMBOLS)) ? CNT_W'(MAX_SYMBOLS) : count_q;
		len_c = n_c;
		for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
			if (CNT_W'(k) < n_c && sym[k] == CH_NUL) begin
				len_c = CNT_W'(k);
			end
		end
	end

	always_comb begin
		bad_c = (len_c < CNT_W'(2));
		for (int a = 0; a < MAX_SYMBOLS; a++) begin
			if (CNT_W'(a) < len_c) begin
				if (sym[a] == CH_PLUS || sym[a] == CH_MINUS) begin
					bad_c = 1'b1;
				end
				for (int b = a + 1; b < MAX_SYMBOLS; b++) begin
					if (CNT_W'(b) < len_c && sym[b] == sym[a]) begin
						bad_c = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			bad_q <= 1'b1;
		end else begin
			len_q <= len_c;
			bad_q <= bad_c;
		end
	end

	assign alpha.len     = len_q;
	assign alpha.bad     = bad_q;
	assign alpha.symbols = sym;

endmodule

`default_nettype wire

// ----- hw/rtl/rsti_parse.sv -----
`default_nettype none

module rsti_parse
	import rsti_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result,
	input  wire alpha_t  alpha
);

	logic               valid_s1;
	item_t              item_s1;
	phase_t             phase_q;
	logic               neg_q;
	logic [VALUE_W-1:0] acc_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_acc_q;
	logic               out_neg_q;
	logic               out_bad_q;

	logic               advance;
	logic               ws;
	logic               hit;
	logic [IDX_W-1:0]   digit;
	logic [VALUE_W-1:0] mac;
	phase_t             phase_n;
	logic               neg_n;
	logic [VALUE_W-1:0] acc_n;
	logic [VALUE_W-1:0] mag;

	// A last item waits only while the result register is still occupied.
	assign advance    = valid_s1 && (!item_s1.is_last || !out_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		hit   = 1'b0;
		digit = '0;
		for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
			if (CNT_W'(k) < alpha.len && alpha.symbols[k] == item_s1.character) begin
				hit   = 1'b1;
				digit = IDX_W'(k);
			end
		end
	end

	assign mac = acc_q * VALUE_W'(alpha.len) + VALUE_W'(digit);
	assign ws  = (item_s1.character >= CH_TAB && item_s1.character <= CH_CR)
		|| item_s1.character == CH_SPACE;

	// One character may walk through the whitespace, sign and digit phases.
	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		if (phase_n == PH_SPACE && !ws) begin
			phase_n = PH_SIGN;
		end
		if (phase_n == PH_SIGN) begin
			if (item_s1.character == CH_MINUS) begin
				neg_n = ~neg_q;
			end else if (item_s1.character != CH_PLUS) begin
				phase_n = PH_DIGIT;
			end
		end
		if (phase_n == PH_DIGIT) begin
			if (item_s1.character == CH_NUL || !hit) begin
				phase_n = PH_STOP;
			end else begin
				acc_n = mac;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (advance) begin
			if (item_s1.is_last) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.is_last) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.is_last) begin
			out_acc_q <= acc_n;
			out_neg_q <= neg_n;
			out_bad_q <= alpha.bad;
		end
	end

	assign mag                     = out_neg_q ? (VALUE_W'(0) - out_acc_q) : out_acc_q;
	assign result_valid            = out_valid_q;
	assign result.value            = out_bad_q ? '1 : $signed(mag);
	assign result.alphabet_invalid = out_bad_q;

endmodule

`default_nettype wire
